// ----- src/crls_pkg.sv -----
package crls_pkg;

  // ring of timestamp pairs; the mean adds half the depth and then shifts arithmetically
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_LOG2 = 4;
  localparam int IDX_W = 4;
  localparam int TS_W = 64;

  // defaults for the fit arithmetic
  localparam int DEF_SLOPE_FRACTION_BITS = 32;
  localparam int DEF_DEVIATION_BITS = 30;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_DEV  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // phases of one ring entry in the deviation pass
  localparam logic [1:0] PH_DEV = 2'd0;
  localparam logic [1:0] PH_SQ  = 2'd1;
  localparam logic [1:0] PH_CR  = 2'd2;
  localparam logic [1:0] PH_ACC = 2'd3;

endpackage

// ----- src/clock_rate_least_squares_core.sv -----
// Least-squares clock rate fit. Each request carries a cpu/offset timestamp
// pair that is written into a 16-entry ring (zero after reset); the block then
// fits offset against cpu over the whole ring and returns the slope (signed,
// SLOPE_FRACTION_BITS fraction bits, saturated), both rounded means, fit_ok
// and a deviation clip flag. When the cpu spread is zero the last fit is
// returned with fit_ok low. A request runs a summing pass over the ring, a
// deviation pass through a single shared multiplier (deviation, square,
// cross product and accumulate steps per entry) and a restoring divider
// producing one quotient bit per cycle; the divider is skipped when the
// spread is zero.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register so a new request can be taken while it waits.
module clock_rate_least_squares_core
  import crls_pkg::*;
#(
  parameter int SLOPE_FRACTION_BITS = DEF_SLOPE_FRACTION_BITS,
  parameter int DEVIATION_BITS = DEF_DEVIATION_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [TS_W-1:0] in_cpu_time,
  input  logic signed [TS_W-1:0] in_offset_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [TS_W-1:0] out_slope,
  output logic signed [TS_W-1:0] out_mean_offset,
  output logic signed [TS_W-1:0] out_mean_cpu,
  output logic                   out_fit_ok,
  output logic                   out_deviation_clipped
);

  localparam int D = DEVIATION_BITS;
  localparam int F = SLOPE_FRACTION_BITS;
  localparam int SUM_W = TS_W + HIST_LOG2 + 1;
  localparam int ACC_W = 2 * D + HIST_LOG2 + 1;
  localparam int N = ACC_W + F;
  localparam int CNT_W = $clog2(N + 1);
  localparam int QX_W = (N > 65) ? N : 65;
  localparam logic signed [64:0] DEV_MAX = (65'sd1 <<< (D - 1)) - 65'sd1;
  localparam logic signed [64:0] DEV_MIN = -(65'sd1 <<< (D - 1));
  localparam logic [QX_W-1:0] POS_LIM = QX_W'(64'h7fff_ffff_ffff_ffff);
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'(64'h8000_0000_0000_0000);

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             ph_r;
  logic [IDX_W-1:0]       wr_ptr_r;
  logic [IDX_W-1:0]       idx_r;
  logic [TS_W-1:0]        cpu_hist_r [HISTORY_DEPTH];
  logic [TS_W-1:0]        off_hist_r [HISTORY_DEPTH];
  logic signed [SUM_W-1:0] sum_cpu_r, sum_off_r;
  logic signed [TS_W-1:0] mc_r, mt_r;
  logic signed [D-1:0]    dc_r, dt_r;
  logic signed [2*D-1:0]  prod_r;
  logic signed [ACC_W-1:0] cc_r, ct_r;
  logic                   clip_r;
  logic                   neg_r;
  logic [N-1:0]           num_r, quot_r;
  logic [ACC_W:0]         rem_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [TS_W-1:0] held_slope_r, held_mt_r, held_mc_r;
  logic                   out_valid_r;
  logic signed [TS_W-1:0] out_slope_r, out_mt_r, out_mc_r;
  logic                   out_ok_r, out_clip_r;

  logic                   in_acc;
  logic                   last_idx;
  logic [TS_W-1:0]        cpu_rd, off_rd;
  logic signed [64:0]     diff_c, diff_t;
  logic signed [D-1:0]    dc_sat, dt_sat;
  logic                   clip_c, clip_t;
  logic signed [D-1:0]    mul_b;
  logic signed [2*D-1:0]  mul_p;
  logic signed [SUM_W-1:0] mc_rnd, mt_rnd;
  logic signed [ACC_W-1:0] ct_mag;
  logic [ACC_W:0]         rem_sh;
  logic                   rem_ge;
  logic [QX_W-1:0]        q_ext;
  logic [TS_W-1:0]        slope_val;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign last_idx  = (idx_r == IDX_W'(HISTORY_DEPTH - 1));
  assign cpu_rd    = cpu_hist_r[idx_r];
  assign off_rd    = off_hist_r[idx_r];

  // rounded means, floor of (sum + half) / depth
  assign mc_rnd = (sum_cpu_r + SUM_W'(HISTORY_DEPTH / 2)) >>> HIST_LOG2;
  assign mt_rnd = (sum_off_r + SUM_W'(HISTORY_DEPTH / 2)) >>> HIST_LOG2;

  // saturated deviations of the current entry
  assign diff_c = $signed({cpu_rd[TS_W-1], cpu_rd}) - $signed({mc_r[TS_W-1], mc_r});
  assign diff_t = $signed({off_rd[TS_W-1], off_rd}) - $signed({mt_r[TS_W-1], mt_r});
  assign clip_c = (diff_c > DEV_MAX) || (diff_c < DEV_MIN);
  assign clip_t = (diff_t > DEV_MAX) || (diff_t < DEV_MIN);
  assign dc_sat = (diff_c > DEV_MAX) ? D'(DEV_MAX) :
                  (diff_c < DEV_MIN) ? D'(DEV_MIN) : D'(diff_c);
  assign dt_sat = (diff_t > DEV_MAX) ? D'(DEV_MAX) :
                  (diff_t < DEV_MIN) ? D'(DEV_MIN) : D'(diff_t);

  // shared multiplier: square first, cross product next
  assign mul_b = (ph_r == PH_SQ) ? dc_r : dt_r;
  assign mul_p = dc_r * mul_b;

  // divider step and slope saturation
  assign ct_mag = ct_r[ACC_W-1] ? -ct_r : ct_r;
  assign rem_sh = {rem_r[ACC_W-1:0], num_r[N-1]};
  assign rem_ge = (rem_sh >= {1'b0, cc_r});
  assign q_ext  = QX_W'(quot_r);
  assign slope_val = neg_r ? ((q_ext > NEG_LIM) ? NEG_LIM[TS_W-1:0] : -q_ext[TS_W-1:0])
                           : ((q_ext > POS_LIM) ? POS_LIM[TS_W-1:0] : q_ext[TS_W-1:0]);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SUM;
      ST_SUM:  if (last_idx) state_nxt = ST_MEAN;
      ST_MEAN: state_nxt = ST_DEV;
      ST_DEV:  if (ph_r == PH_ACC && last_idx) state_nxt = ST_PREP;
      ST_PREP: state_nxt = (cc_r == '0) ? ST_FIN : ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers and ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ph_r         <= PH_DEV;
      idx_r        <= '0;
      wr_ptr_r     <= '0;
      out_valid_r  <= 1'b0;
      held_slope_r <= '0;
      held_mt_r    <= '0;
      held_mc_r    <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        cpu_hist_r[i] <= '0;
        off_hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cpu_hist_r[wr_ptr_r] <= in_cpu_time;
            off_hist_r[wr_ptr_r] <= in_offset_time;
            wr_ptr_r <= wr_ptr_r + 1'b1;
            idx_r    <= '0;
          end
        end
        ST_SUM: idx_r <= idx_r + 1'b1;
        ST_MEAN: begin
          idx_r <= '0;
          ph_r  <= PH_DEV;
        end
        ST_DEV: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == PH_ACC) idx_r <= idx_r + 1'b1;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            if (cc_r != '0) begin
              held_slope_r <= slope_val;
              held_mt_r    <= mt_r;
              held_mc_r    <= mc_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sum_cpu_r <= '0;
        sum_off_r <= '0;
        clip_r    <= 1'b0;
        cc_r      <= '0;
        ct_r      <= '0;
      end
      ST_SUM: begin
        sum_cpu_r <= sum_cpu_r + SUM_W'($signed(cpu_rd));
        sum_off_r <= sum_off_r + SUM_W'($signed(off_rd));
      end
      ST_MEAN: begin
        mc_r <= mc_rnd[TS_W-1:0];
        mt_r <= mt_rnd[TS_W-1:0];
      end
      ST_DEV: begin
        case (ph_r)
          PH_DEV: begin
            dc_r   <= dc_sat;
            dt_r   <= dt_sat;
            clip_r <= clip_r | clip_c | clip_t;
          end
          PH_SQ: prod_r <= mul_p;
          PH_CR: begin
            cc_r   <= cc_r + ACC_W'(prod_r);
            prod_r <= mul_p;
          end
          PH_ACC: ct_r <= ct_r + ACC_W'(prod_r);
          default: ;
        endcase
      end
      ST_PREP: begin
        neg_r  <= ct_r[ACC_W-1];
        num_r  <= (N'(ct_mag) << F) + N'(cc_r >>> 1);
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= CNT_W'(N - 1);
      end
      ST_DIV: begin
        rem_r  <= rem_ge ? (rem_sh - {1'b0, cc_r}) : rem_sh;
        quot_r <= {quot_r[N-2:0], rem_ge};
        num_r  <= num_r << 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_ok_r   <= (cc_r != '0);
          out_clip_r <= clip_r;
          if (cc_r != '0) begin
            out_slope_r <= slope_val;
            out_mt_r    <= mt_r;
            out_mc_r    <= mc_r;
          end else begin
            out_slope_r <= held_slope_r;
            out_mt_r    <= held_mt_r;
            out_mc_r    <= held_mc_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_slope             = out_slope_r;
  assign out_mean_offset       = out_mt_r;
  assign out_mean_cpu          = out_mc_r;
  assign out_fit_ok            = out_ok_r;
  assign out_deviation_clipped = out_clip_r;

  // a taken request always starts the summing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SUM)
    else $error("request did not start summing pass");

  // a new result only appears out of the finishing state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside finishing state");

  // squared cpu spread is never negative
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PREP |-> !cc_r[ACC_W-1])
    else $error("negative sum of squares");

  // a held result repeats the last fitted slope
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_slope_r == held_slope_r)
    else $error("held slope mismatch");

endmodule

// ----- bench/tb_clock_rate_least_squares_core.sv -----
`timescale 1ns / 1ps

module tb_clock_rate_least_squares_core;
  import crls_pkg::*;

  typedef logic signed [TS_W-1:0] ts_t;

  typedef struct {
    ts_t  slope;
    ts_t  mean_offset;
    ts_t  mean_cpu;
    logic fit_ok;
    logic clipped;
  } fit_t;

  // ring model, line fit and the queue of fits still owed by the block
  class fit_scoreboard;
    ts_t      cpu_ring[HISTORY_DEPTH];
    ts_t      ofs_ring[HISTORY_DEPTH];
    bit [3:0] wr_slot;
    fit_t     last_fit;
    fit_t     pending_fits[$];
    int       mismatches;

    function new();
      foreach (cpu_ring[i]) begin
        cpu_ring[i] = '0;
        ofs_ring[i] = '0;
      end
      wr_slot = '0;
      last_fit = '{slope: '0, mean_offset: '0, mean_cpu: '0, fit_ok: 1'b0, clipped: 1'b0};
      mismatches = 0;
    endfunction

    function ts_t ring_mean(ts_t ring[HISTORY_DEPTH]);
      logic signed [71:0] total;
      total = 72'sd8;
      foreach (ring[i]) total = total + ring[i];
      return ts_t'(total >>> HIST_LOG2);
    endfunction

    // deviation from the mean, clipped to a signed 30-bit range
    function ts_t clip_dev(ts_t a, ts_t b, inout bit clip);
      logic signed [64:0] d;
      d = a - b;
      if (d > 65'sd536870911) begin
        clip = 1'b1;
        return 64'sd536870911;
      end
      if (d < -65'sd536870912) begin
        clip = 1'b1;
        return -64'sd536870912;
      end
      return ts_t'(d);
    endfunction

    function void note_request(ts_t cpu, ts_t ofs);
      ts_t                 mc, mo, dc, dt;
      logic signed [127:0] cc, ct;
      logic [127:0]        mag, quo;
      bit                  clip, neg;
      fit_t                r;
      cpu_ring[wr_slot] = cpu;
      ofs_ring[wr_slot] = ofs;
      wr_slot = wr_slot + 4'd1;
      mc = ring_mean(cpu_ring);
      mo = ring_mean(ofs_ring);
      cc = '0;
      ct = '0;
      clip = 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        dc = clip_dev(cpu_ring[i], mc, clip);
        dt = clip_dev(ofs_ring[i], mo, clip);
        cc = cc + dc * dc;
        ct = ct + dc * dt;
      end
      r = last_fit;
      r.fit_ok = 1'b0;
      // zero cpu spread keeps the previous fit
      if (cc != 0) begin
        neg = ct[127];
        mag = neg ? -ct : ct;
        mag = (mag << DEF_SLOPE_FRACTION_BITS) + (cc >> 1);
        quo = mag / cc;
        if (!neg)
          r.slope = (quo > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : quo[63:0];
        else
          r.slope = (quo > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                      : -quo[63:0];
        r.mean_offset = mo;
        r.mean_cpu = mc;
        r.fit_ok = 1'b1;
      end
      r.clipped = clip;
      last_fit = r;
      pending_fits.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h got %h", what, want, got);
      end
    endfunction

    function void check_result(fit_t got);
      fit_t want;
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result with no request outstanding");
        return;
      end
      want = pending_fits.pop_front();
      flag("slope", want.slope, got.slope);
      flag("mean_offset", want.mean_offset, got.mean_offset);
      flag("mean_cpu", want.mean_cpu, got.mean_cpu);
      flag("fit_ok", want.fit_ok, got.fit_ok);
      flag("deviation_clipped", want.clipped, got.clipped);
    endfunction
  endclass

  localparam int STALL_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ts_t  in_cpu_time = '0;
  ts_t  in_offset_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ts_t  out_slope, out_mean_offset, out_mean_cpu;
  logic out_fit_ok, out_deviation_clipped;

  fit_scoreboard fits = new();
  int  quiet_cycles = 0;
  bit  steady_sink = 1'b0;

  clock_rate_least_squares_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cpu_time(in_cpu_time), .in_offset_time(in_offset_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slope(out_slope), .out_mean_offset(out_mean_offset), .out_mean_cpu(out_mean_cpu),
    .out_fit_ok(out_fit_ok), .out_deviation_clipped(out_deviation_clipped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) fits.note_request(in_cpu_time, in_offset_time);
    if (rst_n && out_valid && out_ready)
      fits.check_result('{slope: out_slope, mean_offset: out_mean_offset,
                          mean_cpu: out_mean_cpu, fit_ok: out_fit_ok,
                          clipped: out_deviation_clipped});
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic ts_t rand64();
    return {$urandom, $urandom};
  endfunction

  // result side back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!steady_sink) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  task automatic send_pair(ts_t cpu, ts_t ofs, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cpu_time <= cpu;
    in_offset_time <= ofs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_fits();
    in_valid <= 1'b0;
    while (fits.pending_fits.size() != 0) @(posedge clk);
  endtask

  // steady clock run: cpu advances by a step, offset follows at a drifting rate
  task automatic send_clock_run(int count);
    ts_t cpu, ofs, step, ostep;
    int  mode;
    mode = $urandom_range(0, 3);
    cpu = (mode == 0) ? rand64() : ts_t'($urandom);
    ofs = (mode == 0) ? rand64() : ts_t'($urandom_range(0, 1000000));
    step = (mode == 1) ? ts_t'($urandom_range(1, 16)) : ts_t'($urandom_range(1, 1 << 20));
    ostep = step + $signed($urandom_range(0, 200)) - 100;
    if (mode == 3) ostep = -ostep;
    for (int i = 0; i < count; i++) begin
      cpu = cpu + step + $urandom_range(0, 3);
      ofs = ofs + ostep + $signed($urandom_range(0, 20)) - 10;
      send_pair(cpu, ofs);
    end
  endtask

  localparam ts_t TS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam ts_t TS_MIN = 64'h8000_0000_0000_0000;

  initial begin
    int kind;
    int sent;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero spread straight after reset, then field extremes
    send_pair('0, '0);
    send_pair('0, TS_MAX);
    send_pair(TS_MAX, TS_MIN);
    send_pair(TS_MIN, TS_MAX);
    send_pair(-64'sd1, -64'sd1);
    send_pair(64'sd1, 64'sd1);
    send_pair(TS_MAX, TS_MAX, 1'b1);
    send_pair(TS_MIN, TS_MIN, 1'b1);
    // one cpu value across the whole ring: held fit
    for (int i = 0; i < 17; i++) send_pair(64'sd12345, ts_t'(i) * 64'sd977);

    // the sender waits for every outstanding result
    drain_fits();

    sent = 0;
    while (sent < 1325) begin
      kind = $urandom_range(0, 99);
      steady_sink = (kind < 10);
      if (kind < 60) begin
        send_clock_run(20);
        sent += 20;
      end else if (kind < 70) begin
        for (int i = 0; i < 17; i++) send_pair(TS_MIN + 64'sd5, rand64());
        sent += 17;
      end else if (kind < 85) begin
        for (int i = 0; i < 8; i++) send_pair(rand64(), rand64());
        sent += 8;
      end else if (kind < 95) begin
        for (int i = 0; i < 6; i++)
          send_pair($urandom_range(0, 1) ? TS_MAX - $urandom_range(0, 3)
                                         : TS_MIN + $urandom_range(0, 3),
                    $urandom_range(0, 1) ? TS_MAX : TS_MIN);
        sent += 6;
      end else begin
        send_clock_run(18);
        drain_fits();
        sent += 18;
      end
    end
    steady_sink = 1'b0;

    drain_fits();
    repeat (200) @(posedge clk);
    if (fits.mismatches == 0 && fits.pending_fits.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/crls_pkg.sv
src/clock_rate_least_squares_core.sv
bench/tb_clock_rate_least_squares_core.sv
